@@ rtl/core/sensor_pose_to_body_frame_unit_assert.svh @@
`ifndef SENSOR_POSE_TO_BODY_FRAME_UNIT_ASSERT_SVH
`define SENSOR_POSE_TO_BODY_FRAME_UNIT_ASSERT_SVH
// Assertion helpers, clocked on i_clk and quiet while reset is held.
`define SPB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/core/spbf_pkg.sv @@
package spbf_pkg;
    localparam int AngW = 32;
    localparam int AccW = 40;
    localparam int AtanEntries = 24;
    localparam logic signed [AccW-1:0] CordicGain = 40'sd652032874;

    typedef enum logic [1:0] {
        CFG_READ_PERIOD = 2'd0,
        CFG_OFFSET_X    = 2'd1,
        CFG_OFFSET_Y    = 2'd2,
        CFG_OFFSET_YAW  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL,
        ST_SUM,
        ST_ROUND,
        ST_DONE
    } t_back_state;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic               fresh;
        logic               compute;
        logic               link;
        logic [31:0]        now_ms;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_h;
        logic signed [15:0] raw_vx;
        logic signed [15:0] raw_vy;
        logic signed [15:0] raw_vh;
    } t_job;

    function automatic logic signed [AccW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [AccW-1:0] v;
        case (idx)
            5'd0:  v = 40'sd536870912;
            5'd1:  v = 40'sd316933406;
            5'd2:  v = 40'sd167458907;
            5'd3:  v = 40'sd85004756;
            5'd4:  v = 40'sd42667331;
            5'd5:  v = 40'sd21354465;
            5'd6:  v = 40'sd10679838;
            5'd7:  v = 40'sd5340245;
            5'd8:  v = 40'sd2670163;
            5'd9:  v = 40'sd1335087;
            5'd10: v = 40'sd667544;
            5'd11: v = 40'sd333772;
            5'd12: v = 40'sd166886;
            5'd13: v = 40'sd83443;
            5'd14: v = 40'sd41722;
            5'd15: v = 40'sd20861;
            5'd16: v = 40'sd10430;
            5'd17: v = 40'sd5215;
            5'd18: v = 40'sd2608;
            5'd19: v = 40'sd1304;
            5'd20: v = 40'sd652;
            5'd21: v = 40'sd326;
            5'd22: v = 40'sd163;
            5'd23: v = 40'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

@@ rtl/core/spbf_front.sv @@
module spbf_front
    import spbf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_now_ms,
    input  logic               i_read_ok,
    input  logic signed [15:0] i_raw_x,
    input  logic signed [15:0] i_raw_y,
    input  logic signed [15:0] i_raw_h,
    input  logic signed [15:0] i_raw_vx,
    input  logic signed [15:0] i_raw_vy,
    input  logic signed [15:0] i_raw_vh,
    input  logic [15:0]        i_read_period,
    input  logic               i_q_full,
    output logic               o_push,
    output t_job               o_job
);
    logic        r_has_read;
    logic [31:0] r_last_read;
    logic [31:0] elapsed;
    logic        is_read;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;
    assign elapsed = i_now_ms - r_last_read;
    assign is_read = !r_has_read || (elapsed >= {16'd0, i_read_period});

    always_comb begin
        o_job.fresh   = is_read;
        o_job.compute = is_read && i_read_ok;
        o_job.link    = i_read_ok;
        o_job.now_ms  = i_now_ms;
        o_job.raw_x   = i_raw_x;
        o_job.raw_y   = i_raw_y;
        o_job.raw_h   = i_raw_h;
        o_job.raw_vx  = i_raw_vx;
        o_job.raw_vy  = i_raw_vy;
        o_job.raw_vh  = i_raw_vh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_read  <= 1'b0;
            r_last_read <= '0;
        end else if (o_push && is_read) begin
            r_has_read  <= 1'b1;
            r_last_read <= i_now_ms;
        end
    end
endmodule

@@ rtl/core/spbf_queue.sv @@
module spbf_queue
    import spbf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

@@ rtl/core/spbf_back.sv @@
module spbf_back
    import spbf_pkg::*;
#(
    parameter int FRAC_BITS     = 8,
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_job               i_job,
    output logic               o_pop,
    input  logic signed [15:0] i_offset_x,
    input  logic signed [15:0] i_offset_y,
    input  logic signed [15:0] i_offset_yaw,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [25:0] o_pose_x,
    output logic signed [25:0] o_pose_y,
    output logic signed [15:0] o_pose_h,
    output logic signed [24:0] o_vel_x,
    output logic signed [24:0] o_vel_y,
    output logic signed [15:0] o_yaw_rate,
    output logic               o_sample_valid,
    output logic [31:0]        o_last_update,
    output logic               o_link_ok
);
    localparam int Sh       = 30 - FRAC_BITS;
    localparam int Stages   = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
    localparam int ProdW    = AccW + 16;
    localparam int SumW     = ProdW + 2;
    localparam logic signed [SumW-1:0] Half = SumW'(1) <<< (Sh - 1);

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [4:0]  r_it;
    logic [2:0]  r_mi;

    // Two CORDIC engines in parallel: mounting yaw and sensor heading.
    logic signed [AccW-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic                   r_aflip, r_bflip;
    logic signed [ProdW-1:0] r_p [12];
    logic signed [SumW-1:0]  r_s [4];

    logic signed [25:0] r_hx, r_hy;
    logic signed [24:0] r_hvx, r_hvy;
    logic signed [15:0] r_hh, r_hr;
    logic               r_hv, r_link, r_out_v;
    logic [31:0]        r_stamp;

    logic [AngW-1:0]        ang_a, ang_b, a_adj, b_adj;
    logic                   flip_a, flip_b;
    logic signed [AccW-1:0] atan_v;
    logic signed [AccW-1:0] c, s, ch, sh;
    logic signed [AccW-1:0] m_a, m_b;
    logic signed [15:0]     m_ca, m_cb;
    logic signed [ProdW-1:0] prod_a, prod_b;
    logic signed [SumW-1:0] rnd [4];

    assign ang_a  = {16'(-i_offset_yaw), 16'd0};
    assign ang_b  = {i_job.raw_h, 16'd0};
    assign flip_a = ang_a[31] ^ ang_a[30];
    assign flip_b = ang_b[31] ^ ang_b[30];
    assign a_adj  = flip_a ? ang_a + 32'h8000_0000 : ang_a;
    assign b_adj  = flip_b ? ang_b + 32'h8000_0000 : ang_b;
    assign atan_v = atan_entry(r_it);

    assign c  = r_aflip ? -r_ax : r_ax;
    assign s  = r_aflip ? -r_ay : r_ay;
    assign ch = r_bflip ? -r_bx : r_bx;
    assign sh = r_bflip ? -r_by : r_by;

    // Six multiply slots, two products each, taken in turn.
    always_comb begin
        case (r_mi)
            3'd0: begin m_a = c;  m_ca = r_job.raw_x;  m_b = s;  m_cb = r_job.raw_y; end
            3'd1: begin m_a = ch; m_ca = i_offset_x;   m_b = sh; m_cb = i_offset_y; end
            3'd2: begin m_a = c;  m_ca = r_job.raw_vx; m_b = s;  m_cb = r_job.raw_vy; end
            3'd3: begin m_a = s;  m_ca = r_job.raw_x;  m_b = c;  m_cb = r_job.raw_y; end
            3'd4: begin m_a = sh; m_ca = i_offset_x;   m_b = ch; m_cb = i_offset_y; end
            default: begin m_a = s; m_ca = r_job.raw_vx; m_b = c; m_cb = r_job.raw_vy; end
        endcase
    end
    assign prod_a = ProdW'(m_a) * ProdW'(m_ca);
    assign prod_b = ProdW'(m_b) * ProdW'(m_cb);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rnd[k] = (r_s[k] + Half) >>> Sh;
        end
    end

    function automatic logic signed [25:0] sat26(input logic signed [SumW-1:0] v);
        if (v > SumW'(33554431)) return 26'sh1FFFFFF;
        if (v < -SumW'(33554432)) return -26'sh2000000;
        return v[25:0];
    endfunction
    function automatic logic signed [24:0] sat25(input logic signed [SumW-1:0] v);
        if (v > SumW'(16777215)) return 25'shFFFFFF;
        if (v < -SumW'(16777216)) return -25'sh1000000;
        return v[24:0];
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (!i_q_empty && !r_out_v) n_state = i_job.compute ? ST_CORDIC : ST_DONE;
            ST_CORDIC: if (r_it == 5'(Stages - 1)) n_state = ST_MUL;
            ST_MUL:    if (r_mi == 3'd5) n_state = ST_SUM;
            ST_SUM:    n_state = ST_ROUND;
            ST_ROUND:  n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop = !i_q_empty && !r_out_v;
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job   <= i_job;
            r_it    <= '0;
            r_mi    <= '0;
            r_ax    <= CordicGain;
            r_ay    <= '0;
            r_az    <= AccW'($signed(a_adj));
            r_aflip <= flip_a;
            r_bx    <= CordicGain;
            r_by    <= '0;
            r_bz    <= AccW'($signed(b_adj));
            r_bflip <= flip_b;
        end else if (r_state == ST_CORDIC) begin
            r_it <= r_it + 5'd1;
            if (!r_az[AccW-1]) begin
                r_ax <= r_ax - (r_ay >>> r_it);
                r_ay <= r_ay + (r_ax >>> r_it);
                r_az <= r_az - atan_v;
            end else begin
                r_ax <= r_ax + (r_ay >>> r_it);
                r_ay <= r_ay - (r_ax >>> r_it);
                r_az <= r_az + atan_v;
            end
            if (!r_bz[AccW-1]) begin
                r_bx <= r_bx - (r_by >>> r_it);
                r_by <= r_by + (r_bx >>> r_it);
                r_bz <= r_bz - atan_v;
            end else begin
                r_bx <= r_bx + (r_by >>> r_it);
                r_by <= r_by - (r_bx >>> r_it);
                r_bz <= r_bz + atan_v;
            end
        end else if (r_state == ST_MUL) begin
            r_mi <= r_mi + 3'd1;
            r_p[{r_mi, 1'b0}] <= prod_a;
            r_p[{r_mi, 1'b1}] <= prod_b;
        end else if (r_state == ST_SUM) begin
            // Products 6,7 are s*x and c*y; products 8,9 are sh*ox and ch*oy.
            r_s[0] <= SumW'(r_p[0]) - SumW'(r_p[1]) - SumW'(r_p[2]) + SumW'(r_p[3]);
            r_s[1] <= SumW'(r_p[6]) + SumW'(r_p[7]) - SumW'(r_p[8]) - SumW'(r_p[9]);
            r_s[2] <= SumW'(r_p[4]) - SumW'(r_p[5]);
            r_s[3] <= SumW'(r_p[10]) + SumW'(r_p[11]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hx <= '0; r_hy <= '0; r_hvx <= '0; r_hvy <= '0;
            r_hh <= '0; r_hr <= '0; r_hv <= 1'b0; r_stamp <= '0;
            r_link <= 1'b1; r_out_v <= 1'b0;
        end else begin
            if (o_valid && i_ready) r_out_v <= 1'b0;
            if (r_state == ST_ROUND) begin
                r_hx  <= sat26(rnd[0]);
                r_hy  <= sat26(rnd[1]);
                r_hvx <= sat25(rnd[2]);
                r_hvy <= sat25(rnd[3]);
                r_hh  <= r_job.raw_h;
                r_hr  <= r_job.raw_vh;
                r_stamp <= r_job.now_ms;
            end
            if (r_state == ST_DONE) begin
                r_out_v <= 1'b1;
                r_hv    <= r_job.compute;
                if (r_job.fresh) r_link <= r_job.link;
            end
        end
    end

    assign o_valid        = r_out_v;
    assign o_pose_x       = r_hx;
    assign o_pose_y       = r_hy;
    assign o_pose_h       = r_hh;
    assign o_vel_x        = r_hvx;
    assign o_vel_y        = r_hvy;
    assign o_yaw_rate     = r_hr;
    assign o_sample_valid = r_hv;
    assign o_last_update  = r_stamp;
    assign o_link_ok      = r_link;
endmodule

@@ rtl/core/sensor_pose_to_body_frame_unit.sv @@
// Sensor pose to body frame converter.
// Input channel (i_valid/o_ready) takes one transaction per sensor tick: time,
// read status and six raw sensor words. Output channel (o_valid/i_ready) gives
// one transaction per input with the body-frame pose, velocity and status.
// Configuration channel (i_cfg_valid/o_cfg_ready) writes read period, lever
// arm and mounting yaw; it is always ready. The user must use it only while
// the block is idle; the block itself does not enforce this. A front stage
// classifies each tick (stale, failed read, good read) and pushes it into a
// two-entry queue, so the input keeps flowing while the back end works. A
// good read passes through the two iterative CORDIC engines running side by
// side, the six-slot multiply sequence, a sum and a rounding step before
// o_valid shows; stale and failed ticks go straight to the result. The back
// end can start the next tick in the cycle after the result is taken, so it
// works on one tick at a time.
// Reset clears the held pose to zero, link_ok to 1 and empties the queue.
// When the receiver stalls, the result register holds, the back end stops and
// the queue fills; then o_ready drops.
module sensor_pose_to_body_frame_unit
    import spbf_pkg::*;
#(
    parameter int FRAC_BITS     = 8,
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_now_ms,
    input  logic               i_read_ok,
    input  logic signed [15:0] i_raw_x,
    input  logic signed [15:0] i_raw_y,
    input  logic signed [15:0] i_raw_h,
    input  logic signed [15:0] i_raw_vx,
    input  logic signed [15:0] i_raw_vy,
    input  logic signed [15:0] i_raw_vh,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [25:0] o_pose_x,
    output logic signed [25:0] o_pose_y,
    output logic signed [15:0] o_pose_h,
    output logic signed [24:0] o_vel_x,
    output logic signed [24:0] o_vel_y,
    output logic signed [15:0] o_yaw_rate,
    output logic               o_sample_valid,
    output logic [31:0]        o_last_update,
    output logic               o_link_ok,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    `include "sensor_pose_to_body_frame_unit_assert.svh"

    logic [15:0] r_period;
    logic signed [15:0] r_ox, r_oy, r_oyaw;
    logic q_full, q_empty, push, pop;
    t_job job_in, job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'd10;
            r_ox <= '0; r_oy <= '0; r_oyaw <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_READ_PERIOD: r_period <= i_cfg_data;
                CFG_OFFSET_X:    r_ox     <= i_cfg_data;
                CFG_OFFSET_Y:    r_oy     <= i_cfg_data;
                CFG_OFFSET_YAW:  r_oyaw   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spbf_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_now_ms, .i_read_ok,
        .i_raw_x, .i_raw_y, .i_raw_h, .i_raw_vx, .i_raw_vy, .i_raw_vh,
        .i_read_period(r_period), .i_q_full(q_full), .o_push(push), .o_job(job_in)
    );

    spbf_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(job_in), .o_full(q_full),
        .o_empty(q_empty), .i_pop(pop), .o_job(job_out)
    );

    spbf_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .i_job(job_out), .o_pop(pop),
        .i_offset_x(r_ox), .i_offset_y(r_oy), .i_offset_yaw(r_oyaw),
        .o_valid, .i_ready, .o_pose_x, .o_pose_y, .o_pose_h, .o_vel_x, .o_vel_y,
        .o_yaw_rate, .o_sample_valid, .o_last_update, .o_link_ok
    );

    `SPB_ASSERT_IMPL(a_no_push_full, q_full, !push, "push into full queue")
    `SPB_ASSERT_IMPL(a_no_pop_empty, q_empty, !pop, "pop from empty queue")
    `SPB_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "result dropped while stalled")
endmodule
